### hw/rtl/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types, constants and word functions of the stream cipher engine.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int REG_WORDS     = 16;
  localparam int TAP_IDX       = 13;
  localparam int LEN_BITS_DEF  = 16;
  localparam int MAX_MAC_WORDS = 4;
  localparam int MAX_RESULTS   = 4;
  localparam int MAC_CAP_A     = 4 * MAX_MAC_WORDS;
  localparam int MAC_CAP       = (MAC_CAP_A < 4 * MAX_RESULTS) ? MAC_CAP_A : 4 * MAX_RESULTS;
  localparam logic [31:0] START_KONST = 32'h6996C53A;
  localparam logic [4:0]  MAC_RESET   = 5'd16;

  localparam logic [2:0] OP_KEY     = 3'd0;
  localparam logic [2:0] OP_NONCE   = 3'd1;
  localparam logic [2:0] OP_ENCRYPT = 3'd2;
  localparam logic [2:0] OP_DECRYPT = 3'd3;
  localparam logic [2:0] OP_FINISH  = 3'd4;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] data_bytes;
    logic [2:0]  byte_count;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_bytes;
    logic [2:0]  out_count;
    logic        is_mac;
    logic        last_result;
  } out_item_t;

  typedef enum logic [3:0] {
    CELL_HOLD,
    CELL_STEP,
    CELL_TAPX,
    CELL_MAC,
    CELL_FIB,
    CELL_RESTORE,
    CELL_COPY,
    CELL_XORC,
    CELL_SAVE
  } cell_cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LINIT,
    ST_LPACK,
    ST_LWTAP,
    ST_LWSTEP,
    ST_LPTAP,
    ST_LPSTEP,
    ST_LLTAP,
    ST_LLSTEP,
    ST_LCOPY,
    ST_LDIFF,
    ST_LXOR,
    ST_LSAVE,
    ST_DBYTE,
    ST_DMAC,
    ST_DOUT,
    ST_FMAC,
    ST_FSTEP,
    ST_FTAP,
    ST_FXOR,
    ST_FDIFF,
    ST_FWSTEP,
    ST_FOUT
  } ssc_state_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int c);
    return (x << c) | (x >> (32 - c));
  endfunction

  function automatic logic [31:0] sub1(input logic [31:0] w);
    logic [31:0] v;
    v = w ^ (rotl(w, 5) | rotl(w, 7));
    v = v ^ (rotl(v, 19) | rotl(v, 22));
    return v;
  endfunction

  function automatic logic [31:0] sub2(input logic [31:0] w);
    logic [31:0] v;
    v = w ^ (rotl(w, 7) | rotl(w, 22));
    v = v ^ (rotl(v, 5) | rotl(v, 19));
    return v;
  endfunction

  // Fibonacci start value of register word i (1, 1, 2, 3, ...), modulo 2^32.
  function automatic logic [31:0] fib_word(input int i);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] s;
    a = 32'd1;
    b = 32'd1;
    for (int k = 2; k <= i; k++) begin
      s = a + b;
      a = b;
      b = s;
    end
    return b;
  endfunction

  function automatic logic [31:0] byte_mask(input logic [2:0] n);
    logic [31:0] m;
    case (n)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

### hw/rtl/ssc_cell.sv
// ----------------------------------------------------------------------------
// ssc_cell
// One word of the nonlinear register, its CRC word and its saved copy.
// ----------------------------------------------------------------------------
module ssc_cell
  import ssc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cell_cmd_t   cmd,
  input  logic [31:0] nb_s,
  input  logic [31:0] nb_c,
  input  logic [31:0] mix,
  input  logic [31:0] tap_x,
  input  logic [31:0] load_val,
  output logic [31:0] s_q,
  output logic [31:0] c_q
);

  logic [31:0] s_r;
  logic [31:0] c_r;
  logic [31:0] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= '0;
      c_r <= '0;
    end else begin
      case (cmd)
        CELL_STEP:    s_r <= nb_s ^ mix;
        CELL_TAPX:    s_r <= s_r ^ tap_x;
        CELL_MAC: begin
          s_r <= s_r ^ tap_x;
          c_r <= nb_c;
        end
        CELL_FIB:     s_r <= load_val;
        CELL_RESTORE: s_r <= v_r;
        CELL_COPY:    c_r <= s_r;
        CELL_XORC:    s_r <= s_r ^ c_r;
        default:      s_r <= s_r;
      endcase
    end
  end

  // The saved copy has no reset; it is defined by the first key.
  always_ff @(posedge clk) begin
    if (cmd == CELL_SAVE) begin
      v_r <= s_r;
    end
  end

  assign s_q = s_r;
  assign c_q = c_r;

endmodule

### hw/rtl/shannon_stream_cipher_mac.sv
// ----------------------------------------------------------------------------
// shannon_stream_cipher_mac
// Stream cipher engine with MAC built on a row of sixteen register cells.
// ----------------------------------------------------------------------------
// Items enter on in_valid/in_stall and results leave on out_valid/out_stall;
// a transfer happens when valid is high and stall is low. The MAC length is
// written on cfg_valid/cfg_ready, which is always ready; write it only while
// the block is idle. One item is worked on at a time, and in_stall is high
// from the transfer until the item's last result has entered the output
// register. A key or nonce item packs its bytes; the final item of a load also
// runs 16 diffusion steps and the folding steps, and a key adds a save step.
// Encrypt or decrypt works byte by byte, stepping the keystream and folding in
// completed MAC words. Finish folds in any partial MAC word, runs 16 diffusion
// steps and then emits the MAC words.
// A result sits in the output register until taken; while out_stall holds,
// the sequencer waits in the state that emits the next result.
// Reset clears the register, CRC and load state and sets the MAC length to
// sixteen bytes; the saved key state is defined by the first key.
// ----------------------------------------------------------------------------
module shannon_stream_cipher_mac
  import ssc_pkg::*;
#(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data
);

  ssc_state_t state_r, state_nxt;

  logic [2:0]          op_r;
  logic [31:0]         data_r;
  logic [2:0]          n_r;
  logic                last_r;
  logic [31:0]         k_r;
  logic [31:0]         ks_r;
  logic [31:0]         pt_r;
  logic [5:0]          bl_r;
  logic                loading_r;
  logic [LEN_BITS-1:0] len_r;
  logic [4:0]          mac_bytes_r;
  logic [31:0]         wword_r;
  logic [2:0]          j_r;
  logic [31:0]         res_r;
  logic [3:0]          cnt_r;
  logic [4:0]          want_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  cell_cmd_t   cmd;
  logic [31:0] tap_x;
  logic [31:0] s_w [REG_WORDS];
  logic [31:0] c_w [REG_WORDS];
  logic [31:0] t_fb;
  logic [31:0] t_out;
  logic [31:0] crc_in;
  logic [31:0] ks_nxt;

  logic        in_acc;
  logic        out_free;
  logic        out_load;
  logic [2:0]  n_in;

  // Register step and CRC feedback computed from the row.
  assign t_fb   = sub1(s_w[12] ^ s_w[13] ^ k_r) ^ rotl(s_w[0], 1);
  assign t_out  = sub2(s_w[3] ^ t_fb);
  assign ks_nxt = t_out ^ s_w[9] ^ s_w[13];
  assign crc_in = c_w[0] ^ c_w[2] ^ c_w[15] ^ tap_x;

  for (genvar i = 0; i < REG_WORDS; i++) begin : g_cell
    ssc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .nb_s     ((i == REG_WORDS - 1) ? t_fb : s_w[(i + 1) % REG_WORDS]),
      .nb_c     ((i == REG_WORDS - 1) ? crc_in : c_w[(i + 1) % REG_WORDS]),
      .mix      ((i == 0) ? t_out : 32'd0),
      .tap_x    ((i == TAP_IDX) ? tap_x : 32'd0),
      .load_val (fib_word(i)),
      .s_q      (s_w[i]),
      .c_q      (c_w[i])
    );
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign n_in      = (in_data.byte_count > 3'd4) ? 3'd4 : in_data.byte_count;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = ((state_r == ST_DOUT) || (state_r == ST_FOUT)) && out_free;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Packing of key or nonce bytes into the partial word.
  logic [63:0] pk_comb;
  logic [6:0]  pk_total;
  logic        pk_word;
  logic [31:0] pk_pt;
  logic [5:0]  pk_bl;

  always_comb begin
    pk_comb  = {32'd0, pt_r} | ({32'd0, data_r & byte_mask(n_r)} << bl_r[4:0]);
    pk_total = 7'(bl_r) + 7'({n_r, 3'b000});
    pk_word  = (pk_total >= 7'd32);
    pk_pt    = pk_word ? pk_comb[63:32] : pk_comb[31:0];
    pk_bl    = pk_word ? 6'(pk_total - 7'd32) : 6'(pk_total);
  end

  logic [LEN_BITS:0] len_sum;
  assign len_sum = {1'b0, len_r} + (LEN_BITS + 1)'(n_r);

  // Byte path of encrypt and decrypt.
  logic [4:0]  ks_sh;
  logic [7:0]  db_in;
  logic [7:0]  db_ks;
  logic [7:0]  db_c;
  logic [7:0]  db_p;
  logic        d_done;

  always_comb begin
    ks_sh  = 5'(6'd32 - bl_r);
    db_in  = data_r[{j_r[1:0], 3'b000} +: 8];
    db_ks  = 8'(ks_r >> ks_sh);
    db_c   = db_in ^ db_ks;
    db_p   = (op_r == OP_ENCRYPT) ? db_in : db_c;
    d_done = (j_r == n_r);
  end

  logic [2:0] fo_cnt;
  assign fo_cnt = (want_r >= 5'd4) ? 3'd4 : want_r[2:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.opcode)
            OP_KEY, OP_NONCE: state_nxt = loading_r ? ST_LPACK : ST_LINIT;
            OP_ENCRYPT, OP_DECRYPT: state_nxt = ST_DBYTE;
            OP_FINISH: state_nxt = (!loading_r && bl_r != 6'd0) ? ST_FMAC : ST_FSTEP;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LINIT:  state_nxt = ST_LPACK;
      ST_LPACK: begin
        if (pk_word) begin
          state_nxt = ST_LWTAP;
        end else if (last_r) begin
          state_nxt = (pk_bl != 6'd0) ? ST_LPTAP : ST_LLTAP;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LWTAP:  state_nxt = ST_LWSTEP;
      ST_LWSTEP: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = (bl_r != 6'd0) ? ST_LPTAP : ST_LLTAP;
        end
      end
      ST_LPTAP:  state_nxt = ST_LPSTEP;
      ST_LPSTEP: state_nxt = ST_LLTAP;
      ST_LLTAP:  state_nxt = ST_LLSTEP;
      ST_LLSTEP: state_nxt = ST_LCOPY;
      ST_LCOPY:  state_nxt = ST_LDIFF;
      ST_LDIFF:  state_nxt = (cnt_r == 4'd15) ? ST_LXOR : ST_LDIFF;
      ST_LXOR:   state_nxt = (op_r == OP_KEY) ? ST_LSAVE : ST_IDLE;
      ST_LSAVE:  state_nxt = ST_IDLE;
      ST_DBYTE: begin
        if (d_done) begin
          state_nxt = ST_DOUT;
        end else if (bl_r != 6'd0 && bl_r == 6'd8) begin
          state_nxt = ST_DMAC;
        end else begin
          state_nxt = ST_DBYTE;
        end
      end
      ST_DMAC:   state_nxt = ST_DBYTE;
      ST_DOUT:   state_nxt = out_free ? ST_IDLE : ST_DOUT;
      ST_FMAC:   state_nxt = ST_FSTEP;
      ST_FSTEP:  state_nxt = ST_FTAP;
      ST_FTAP:   state_nxt = ST_FXOR;
      ST_FXOR:   state_nxt = ST_FDIFF;
      ST_FDIFF: begin
        if (cnt_r == 4'd15) begin
          state_nxt = (want_r == 5'd0) ? ST_FOUT : ST_FWSTEP;
        end
      end
      ST_FWSTEP: state_nxt = ST_FOUT;
      ST_FOUT: begin
        if (out_free) begin
          state_nxt = (want_r != 5'(fo_cnt)) ? ST_FWSTEP : ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Cell row command for the current state.
  always_comb begin
    cmd   = CELL_HOLD;
    tap_x = 32'd0;
    case (state_r)
      ST_LINIT:  cmd = (op_r == OP_KEY) ? CELL_FIB : CELL_RESTORE;
      ST_LWTAP: begin
        cmd   = CELL_TAPX;
        tap_x = wword_r;
      end
      ST_LPTAP: begin
        cmd   = CELL_TAPX;
        tap_x = pt_r;
      end
      ST_LLTAP: begin
        cmd   = CELL_TAPX;
        tap_x = 32'(len_r);
      end
      ST_LWSTEP, ST_LPSTEP, ST_LLSTEP, ST_LDIFF,
      ST_FSTEP, ST_FDIFF, ST_FWSTEP: cmd = CELL_STEP;
      ST_LCOPY:  cmd = CELL_COPY;
      ST_LXOR, ST_FXOR: cmd = CELL_XORC;
      ST_LSAVE:  cmd = CELL_SAVE;
      ST_DBYTE:  cmd = (!d_done && bl_r == 6'd0) ? CELL_STEP : CELL_HOLD;
      ST_DMAC, ST_FMAC: begin
        cmd   = CELL_MAC;
        tap_x = pt_r;
      end
      ST_FTAP: begin
        cmd   = CELL_TAPX;
        tap_x = START_KONST ^ {23'd0, bl_r, 3'b000};
      end
      default:   cmd = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      ks_r        <= '0;
      pt_r        <= '0;
      bl_r        <= '0;
      loading_r   <= 1'b0;
      len_r       <= '0;
      mac_bytes_r <= MAC_RESET;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      want_r      <= '0;
      j_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        mac_bytes_r <= cfg_data;
      end
      if (cmd == CELL_STEP) begin
        ks_r <= ks_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            j_r    <= '0;
            want_r <= (mac_bytes_r > 5'(MAC_CAP)) ? 5'(MAC_CAP) : mac_bytes_r;
            // Data or finish abandons an unfinished load.
            if (loading_r && in_data.opcode >= OP_ENCRYPT && in_data.opcode <= OP_FINISH) begin
              loading_r <= 1'b0;
              bl_r      <= '0;
              pt_r      <= '0;
              len_r     <= '0;
            end
          end
        end
        ST_LINIT: begin
          k_r       <= START_KONST;
          loading_r <= 1'b1;
          bl_r      <= '0;
          pt_r      <= '0;
          len_r     <= '0;
        end
        ST_LPACK: begin
          pt_r  <= pk_pt;
          bl_r  <= pk_bl;
          len_r <= len_sum[LEN_BITS] ? '1 : len_sum[LEN_BITS-1:0];
        end
        ST_LCOPY: cnt_r <= '0;
        ST_LDIFF: cnt_r <= cnt_r + 4'd1;
        ST_LXOR: begin
          k_r       <= s_w[0] ^ c_w[0];
          loading_r <= 1'b0;
          bl_r      <= '0;
          pt_r      <= '0;
          len_r     <= '0;
        end
        ST_DBYTE: begin
          if (!d_done) begin
            if (bl_r == 6'd0) begin
              pt_r <= '0;
              bl_r <= 6'd32;
            end else begin
              pt_r <= pt_r ^ (32'(db_p) << ks_sh);
              bl_r <= bl_r - 6'd8;
              j_r  <= j_r + 3'd1;
            end
          end
        end
        ST_FTAP:  bl_r  <= '0;
        ST_FXOR:  cnt_r <= '0;
        ST_FDIFF: cnt_r <= cnt_r + 4'd1;
        ST_FOUT: begin
          if (out_free) begin
            want_r <= want_r - 5'(fo_cnt);
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_data.opcode;
      data_r <= in_data.data_bytes;
      n_r    <= n_in;
      last_r <= in_data.last;
      res_r  <= '0;
    end
    if (state_r == ST_LPACK) begin
      wword_r <= pk_comb[31:0];
    end
    if (state_r == ST_DBYTE && !d_done && bl_r != 6'd0) begin
      res_r <= res_r | (32'(db_c) << {j_r[1:0], 3'b000});
    end
    if (state_r == ST_DOUT && out_free) begin
      out_data_r.out_bytes   <= res_r;
      out_data_r.out_count   <= n_r;
      out_data_r.is_mac      <= 1'b0;
      out_data_r.last_result <= 1'b1;
    end
    if (state_r == ST_FOUT && out_free) begin
      out_data_r.out_bytes   <= ks_r & byte_mask(fo_cnt);
      out_data_r.out_count   <= fo_cnt;
      out_data_r.is_mac      <= 1'b1;
      out_data_r.last_result <= (want_r == 5'(fo_cnt));
    end
  end

  // Keystream bit count only ever moves in whole bytes.
  a_bl_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    bl_r[2:0] == 3'd0 && bl_r <= 6'd32)
    else $error("bits_left out of range");

  // During a load the partial word never holds a full word.
  a_load_partial: assert property (@(posedge clk) disable iff (!rst_n)
    loading_r |-> bl_r < 6'd32)
    else $error("load partial word overflow");

  a_want_cap: assert property (@(posedge clk) disable iff (!rst_n)
    want_r <= 5'(MAC_CAP))
    else $error("MAC byte count above cap");

  // An accepted item keeps the input side closed in the next cycle.
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.opcode <= OP_FINISH |=> in_stall)
    else $error("input reopened before item was worked");

endmodule
